// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define SBC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sbc assertion failed");

// Clocked check that also runs during reset.
`define SBC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("sbc reset assertion failed");

`endif

// ----- hw/rtl/sbc_pkg.sv -----
package sbc_pkg;

    localparam int POS_W     = 32;
    localparam int EXT_W     = 31;
    localparam int SUM_W     = 35;
    localparam int TOL_W     = 10;
    localparam int MASK_W    = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic [TOL_W-1:0] Y_TOL    = TOL_W'(655);
    localparam logic [TOL_W-1:0] NO_TOL   = '0;
    localparam logic [EXT_W-1:0] EXT_INIT = EXT_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_BODY_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_DEPTH  = 2'd2;

    localparam int MB_Z_BACK  = 0;
    localparam int MB_Z_FRONT = 1;
    localparam int MB_Y_ABOVE = 2;
    localparam int MB_Y_BELOW = 3;
    localparam int MB_X_RIGHT = 4;
    localparam int MB_X_LEFT  = 5;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    typedef struct packed {
        logic signed [SUM_W-1:0] hi;
        logic signed [POS_W-1:0] obs;
        logic                    lo_lt;
        logic                    at_end;
        logic                    near;
        logic signed [POS_W-1:0] snap_up;
        logic signed [POS_W-1:0] snap_dn;
        logic signed [POS_W-1:0] pos;
        logic signed [POS_W-1:0] vel;
    } t_axis_res;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic same;
        same = (&v[SUM_W-1:POS_W-1]) | ~(|v[SUM_W-1:POS_W-1]);
        if (same) begin
            return v[POS_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

endpackage

// ----- hw/rtl/sbc_ctrl.sv -----
module sbc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_ready,
    output logic                  o_ready,
    output logic                  o_valid,
    output sbc_pkg::t_stage_en    o_en
);

    logic r_v1, r_v2, r_v3;
    sbc_pkg::t_stage_en en;

    always_comb begin
        en.s3 = !r_v3 || i_ready;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en.s1) begin
                r_v1 <= i_valid;
            end
            if (en.s2) begin
                r_v2 <= r_v1;
            end
            if (en.s3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_en    = en;
    assign o_ready = en.s1;
    assign o_valid = r_v3;

endmodule

// ----- hw/rtl/sbc_axis.sv -----
module sbc_axis (
    input  logic                                 i_clk,
    input  sbc_pkg::t_stage_en                   i_en,
    input  logic                                 i_neg,
    input  logic        [sbc_pkg::TOL_W-1:0]     i_tol,
    input  logic signed [sbc_pkg::POS_W-1:0]     i_pos,
    input  logic        [sbc_pkg::EXT_W-1:0]     i_ext,
    input  logic signed [sbc_pkg::POS_W-1:0]     i_vel,
    input  logic signed [sbc_pkg::POS_W-1:0]     i_obs,
    input  logic        [sbc_pkg::EXT_W-1:0]     i_obs_ext,
    output sbc_pkg::t_axis_res                   o_res
);

    localparam int SW = sbc_pkg::SUM_W;
    localparam int PW = sbc_pkg::POS_W;

    logic signed [SW-1:0] pos_w, vel_w, obs_w, ext_w, oext_w, vaff;
    logic signed [SW-1:0] r_ae, r_lo, r_oend, r_oneg, r_vaff;
    logic signed [PW-1:0] r_pos, r_vel, r_obs;
    logic signed [SW-1:0] hi, r_pos_w, r_obs_w, ae_tol;
    sbc_pkg::t_axis_res   n_res, r_res;

    // stage 1: edge sums
    always_comb begin
        pos_w  = SW'(i_pos);
        vel_w  = SW'(i_vel);
        obs_w  = SW'(i_obs);
        ext_w  = signed'(SW'(i_ext));
        oext_w = signed'(SW'(i_obs_ext));
        vaff   = i_neg ? -vel_w : vel_w;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_ae   <= pos_w + ext_w;
            r_lo   <= pos_w + vaff;
            r_oend <= obs_w + oext_w;
            r_oneg <= obs_w - ext_w;
            r_vaff <= vaff;
            r_pos  <= i_pos;
            r_vel  <= i_vel;
            r_obs  <= i_obs;
        end
    end

    // stage 2: far edge, face compares, snap targets
    always_comb begin
        r_pos_w = SW'(r_pos);
        r_obs_w = SW'(r_obs);
        hi      = r_ae + r_vaff;
        ae_tol  = r_ae - signed'(SW'(i_tol));

        n_res.hi      = hi;
        n_res.obs     = r_obs;
        n_res.lo_lt   = r_lo < r_oend;
        n_res.at_end  = r_pos_w >= r_oend;
        n_res.near    = ae_tol <= r_obs_w;
        n_res.snap_up = sbc_pkg::sat_pos(r_oend);
        n_res.snap_dn = sbc_pkg::sat_pos(r_oneg);
        n_res.pos     = r_pos;
        n_res.vel     = r_vel;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

// ----- hw/rtl/sbc_resolve.sv -----
module sbc_resolve (
    input  logic                                 i_clk,
    input  sbc_pkg::t_stage_en                   i_en,
    input  sbc_pkg::t_axis_res                   i_ax,
    input  sbc_pkg::t_axis_res                   i_ay,
    input  sbc_pkg::t_axis_res                   i_az,
    output logic signed [sbc_pkg::POS_W-1:0]     o_pos_x,
    output logic signed [sbc_pkg::POS_W-1:0]     o_pos_y,
    output logic signed [sbc_pkg::POS_W-1:0]     o_pos_z,
    output logic signed [sbc_pkg::POS_W-1:0]     o_vel_x,
    output logic signed [sbc_pkg::POS_W-1:0]     o_vel_y,
    output logic signed [sbc_pkg::POS_W-1:0]     o_vel_z,
    output logic        [sbc_pkg::MASK_W-1:0]    o_mask
);

    localparam int SW = sbc_pkg::SUM_W;
    localparam int PW = sbc_pkg::POS_W;

    logic hgt_x, hgt_y, hgt_z;
    logic ovl_x, ovl_y, ovl_z;
    logic up_x, up_y, up_z, dn_x, dn_y, dn_z;
    logic hit_xy, hit_xz, hit_zy;

    logic signed [PW-1:0] n_pos_x, n_pos_y, n_pos_z, n_vel_x, n_vel_y, n_vel_z;
    logic signed [PW-1:0] r_pos_x, r_pos_y, r_pos_z, r_vel_x, r_vel_y, r_vel_z;
    logic [sbc_pkg::MASK_W-1:0] n_mask, r_mask;

    always_comb begin
        hgt_x = i_ax.hi > SW'(i_ax.obs);
        hgt_y = i_ay.hi > SW'(i_ay.obs);
        hgt_z = i_az.hi > SW'(i_az.obs);

        ovl_x = hgt_x && i_ax.lo_lt;
        ovl_y = hgt_y && i_ay.lo_lt;
        ovl_z = hgt_z && i_az.lo_lt;

        up_x = i_ax.at_end && i_ax.lo_lt;
        up_y = i_ay.at_end && i_ay.lo_lt;
        up_z = i_az.at_end && i_az.lo_lt;
        dn_x = i_ax.near && hgt_x;
        dn_y = i_ay.near && hgt_y;
        dn_z = i_az.near && hgt_z;

        hit_xy = ovl_x && ovl_y;
        hit_xz = ovl_x && ovl_z;
        hit_zy = ovl_z && ovl_y;

        n_mask  = '0;
        n_pos_x = i_ax.pos;
        n_pos_y = i_ay.pos;
        n_pos_z = i_az.pos;
        n_vel_x = i_ax.vel;
        n_vel_y = i_ay.vel;
        n_vel_z = i_az.vel;

        if (hit_xy && up_z) begin
            n_pos_z = i_az.snap_up;
            n_vel_z = '0;
            n_mask[sbc_pkg::MB_Z_BACK] = 1'b1;
        end else if (hit_xy && dn_z) begin
            n_pos_z = i_az.snap_dn;
            n_vel_z = '0;
            n_mask[sbc_pkg::MB_Z_FRONT] = 1'b1;
        end

        if (hit_xz && up_y) begin
            n_pos_y = i_ay.snap_up;
            n_vel_y = '0;
            n_mask[sbc_pkg::MB_Y_ABOVE] = 1'b1;
        end else if (hit_xz && dn_y) begin
            n_pos_y = i_ay.snap_dn;
            n_vel_y = '0;
            n_mask[sbc_pkg::MB_Y_BELOW] = 1'b1;
        end

        if (hit_zy && dn_x) begin
            n_pos_x = i_ax.snap_dn;
            n_vel_x = '0;
            n_mask[sbc_pkg::MB_X_RIGHT] = 1'b1;
        end else if (hit_zy && up_x) begin
            n_pos_x = i_ax.snap_up;
            n_vel_x = '0;
            n_mask[sbc_pkg::MB_X_LEFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
            r_vel_x <= n_vel_x;
            r_vel_y <= n_vel_y;
            r_vel_z <= n_vel_z;
            r_mask  <= n_mask;
        end
    end

    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;
    assign o_pos_z = r_pos_z;
    assign o_vel_x = r_vel_x;
    assign o_vel_y = r_vel_y;
    assign o_vel_z = r_vel_z;
    assign o_mask  = r_mask;

endmodule

// ----- hw/rtl/swept_box_collision_correct.sv -----
// Swept box contact correction, signed Q16.16. Each item pairs a moving box (min corner and
// per-step velocity, with the x velocity taken negated in every test) with a fixed obstacle
// box; the moving box extents come from three configuration registers (index 0 width,
// 1 height, 2 depth, reset 1.0), to be written only while the block is idle; the user is bound
// by this and the block itself does not enforce it. The block runs a swept overlap test in the
// xy, xz and zy planes and, where a plane overlaps and the box crosses an obstacle face on the
// remaining axis, snaps that coordinate to the face (saturated) and zeroes that velocity,
// flagging the face in the contact mask. The datapath is a three-stage pipeline (edge sums,
// face compares and snap targets, plane decisions into the output register): one item per clock
// while the output is not stalled; a stalled output holds each occupied stage without loss.
module swept_box_collision_correct (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic        [sbc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic        [sbc_pkg::EXT_W-1:0]       i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [sbc_pkg::POS_W-1:0]       i_body_x,
    input  logic signed [sbc_pkg::POS_W-1:0]       i_body_y,
    input  logic signed [sbc_pkg::POS_W-1:0]       i_body_z,
    input  logic signed [sbc_pkg::POS_W-1:0]       i_vel_x,
    input  logic signed [sbc_pkg::POS_W-1:0]       i_vel_y,
    input  logic signed [sbc_pkg::POS_W-1:0]       i_vel_z,
    input  logic signed [sbc_pkg::POS_W-1:0]       i_obstacle_x,
    input  logic signed [sbc_pkg::POS_W-1:0]       i_obstacle_y,
    input  logic signed [sbc_pkg::POS_W-1:0]       i_obstacle_z,
    input  logic        [sbc_pkg::EXT_W-1:0]       i_obstacle_w,
    input  logic        [sbc_pkg::EXT_W-1:0]       i_obstacle_h,
    input  logic        [sbc_pkg::EXT_W-1:0]       i_obstacle_d,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [sbc_pkg::POS_W-1:0]       o_out_x,
    output logic signed [sbc_pkg::POS_W-1:0]       o_out_y,
    output logic signed [sbc_pkg::POS_W-1:0]       o_out_z,
    output logic signed [sbc_pkg::POS_W-1:0]       o_out_vel_x,
    output logic signed [sbc_pkg::POS_W-1:0]       o_out_vel_y,
    output logic signed [sbc_pkg::POS_W-1:0]       o_out_vel_z,
    output logic        [sbc_pkg::MASK_W-1:0]      o_contact_mask
);

    logic [sbc_pkg::EXT_W-1:0] r_body_width, r_body_height, r_body_depth;
    sbc_pkg::t_stage_en        en;
    sbc_pkg::t_axis_res        res_x, res_y, res_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_width  <= sbc_pkg::EXT_INIT;
            r_body_height <= sbc_pkg::EXT_INIT;
            r_body_depth  <= sbc_pkg::EXT_INIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sbc_pkg::CFG_BODY_WIDTH:  r_body_width  <= i_cfg_data;
                sbc_pkg::CFG_BODY_HEIGHT: r_body_height <= i_cfg_data;
                sbc_pkg::CFG_BODY_DEPTH:  r_body_depth  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_en    (en)
    );

    sbc_axis u_axis_x (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_neg     (1'b1),
        .i_tol     (sbc_pkg::NO_TOL),
        .i_pos     (i_body_x),
        .i_ext     (r_body_width),
        .i_vel     (i_vel_x),
        .i_obs     (i_obstacle_x),
        .i_obs_ext (i_obstacle_w),
        .o_res     (res_x)
    );

    sbc_axis u_axis_y (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_neg     (1'b0),
        .i_tol     (sbc_pkg::Y_TOL),
        .i_pos     (i_body_y),
        .i_ext     (r_body_height),
        .i_vel     (i_vel_y),
        .i_obs     (i_obstacle_y),
        .i_obs_ext (i_obstacle_h),
        .o_res     (res_y)
    );

    sbc_axis u_axis_z (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_neg     (1'b0),
        .i_tol     (sbc_pkg::NO_TOL),
        .i_pos     (i_body_z),
        .i_ext     (r_body_depth),
        .i_vel     (i_vel_z),
        .i_obs     (i_obstacle_z),
        .i_obs_ext (i_obstacle_d),
        .o_res     (res_z)
    );

    sbc_resolve u_resolve (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_ax    (res_x),
        .i_ay    (res_y),
        .i_az    (res_z),
        .o_pos_x (o_out_x),
        .o_pos_y (o_out_y),
        .o_pos_z (o_out_z),
        .o_vel_x (o_out_vel_x),
        .o_vel_y (o_out_vel_y),
        .o_vel_z (o_out_vel_z),
        .o_mask  (o_contact_mask)
    );

endmodule

// ----- hw/rtl/sbc_checker.sv -----
`include "assert_macros.svh"

module sbc_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   o_ready,
    input  logic                                   o_valid,
    input  logic                                   i_ready,
    input  logic signed [sbc_pkg::POS_W-1:0]       o_out_x,
    input  logic signed [sbc_pkg::POS_W-1:0]       o_out_vel_x,
    input  logic signed [sbc_pkg::POS_W-1:0]       o_out_vel_y,
    input  logic signed [sbc_pkg::POS_W-1:0]       o_out_vel_z,
    input  logic        [sbc_pkg::MASK_W-1:0]      o_contact_mask
);

    `SBC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid)

    `SBC_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_out_x) && $stable(o_contact_mask))

    `SBC_ASSERT(a_one_face, o_valid |-> !(o_contact_mask[sbc_pkg::MB_Z_BACK] && o_contact_mask[sbc_pkg::MB_Z_FRONT]) && !(o_contact_mask[sbc_pkg::MB_Y_ABOVE] && o_contact_mask[sbc_pkg::MB_Y_BELOW]) && !(o_contact_mask[sbc_pkg::MB_X_RIGHT] && o_contact_mask[sbc_pkg::MB_X_LEFT]))

    `SBC_ASSERT(a_vel_zeroed, o_valid && (o_contact_mask != '0) |-> ((!o_contact_mask[sbc_pkg::MB_X_RIGHT] && !o_contact_mask[sbc_pkg::MB_X_LEFT]) || o_out_vel_x == '0) && ((!o_contact_mask[sbc_pkg::MB_Y_ABOVE] && !o_contact_mask[sbc_pkg::MB_Y_BELOW]) || o_out_vel_y == '0) && ((!o_contact_mask[sbc_pkg::MB_Z_BACK] && !o_contact_mask[sbc_pkg::MB_Z_FRONT]) || o_out_vel_z == '0))

    `SBC_ASSERT(a_flow_through, o_valid && i_ready |-> o_ready)

endmodule

bind swept_box_collision_correct sbc_checker u_sbc_checker (.*);

// ----- bench/tb_swept_box_collision_correct.sv -----
`timescale 1ns / 1ps

module tb_swept_box_collision_correct;

    localparam int     ONE          = 65536;
    localparam longint Q_MAX        = 64'sd2147483647;
    localparam longint Q_MIN        = -64'sd2147483648;
    localparam int     STALL_CYCLES = 120;
    localparam int     DRAIN_CYCLES = 6;
    localparam int     CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic signed [sbc_pkg::POS_W-1:0] bx;
        logic signed [sbc_pkg::POS_W-1:0] by;
        logic signed [sbc_pkg::POS_W-1:0] bz;
        logic signed [sbc_pkg::POS_W-1:0] vx;
        logic signed [sbc_pkg::POS_W-1:0] vy;
        logic signed [sbc_pkg::POS_W-1:0] vz;
        logic signed [sbc_pkg::POS_W-1:0] ox;
        logic signed [sbc_pkg::POS_W-1:0] oy;
        logic signed [sbc_pkg::POS_W-1:0] oz;
        logic        [sbc_pkg::EXT_W-1:0] ow;
        logic        [sbc_pkg::EXT_W-1:0] oh;
        logic        [sbc_pkg::EXT_W-1:0] od;
    } t_box_pair;

    typedef struct packed {
        logic signed [sbc_pkg::POS_W-1:0] x;
        logic signed [sbc_pkg::POS_W-1:0] y;
        logic signed [sbc_pkg::POS_W-1:0] z;
        logic signed [sbc_pkg::POS_W-1:0] vx;
        logic signed [sbc_pkg::POS_W-1:0] vy;
        logic signed [sbc_pkg::POS_W-1:0] vz;
        logic        [sbc_pkg::MASK_W-1:0] mask;
    } t_correction;

    logic                             i_clk        = 1'b0;
    logic                             i_rst_n      = 1'b0;
    logic                             i_cfg_we     = 1'b0;
    logic [sbc_pkg::CFG_IDX_W-1:0]    i_cfg_idx    = sbc_pkg::CFG_BODY_WIDTH;
    logic [sbc_pkg::EXT_W-1:0]        i_cfg_data   = '0;
    logic                             i_valid      = 1'b0;
    logic                             o_ready;
    logic signed [sbc_pkg::POS_W-1:0] i_body_x     = '0;
    logic signed [sbc_pkg::POS_W-1:0] i_body_y     = '0;
    logic signed [sbc_pkg::POS_W-1:0] i_body_z     = '0;
    logic signed [sbc_pkg::POS_W-1:0] i_vel_x      = '0;
    logic signed [sbc_pkg::POS_W-1:0] i_vel_y      = '0;
    logic signed [sbc_pkg::POS_W-1:0] i_vel_z      = '0;
    logic signed [sbc_pkg::POS_W-1:0] i_obstacle_x = '0;
    logic signed [sbc_pkg::POS_W-1:0] i_obstacle_y = '0;
    logic signed [sbc_pkg::POS_W-1:0] i_obstacle_z = '0;
    logic [sbc_pkg::EXT_W-1:0]        i_obstacle_w = '0;
    logic [sbc_pkg::EXT_W-1:0]        i_obstacle_h = '0;
    logic [sbc_pkg::EXT_W-1:0]        i_obstacle_d = '0;
    logic                             o_valid;
    logic                             i_ready      = 1'b0;
    logic signed [sbc_pkg::POS_W-1:0] o_out_x;
    logic signed [sbc_pkg::POS_W-1:0] o_out_y;
    logic signed [sbc_pkg::POS_W-1:0] o_out_z;
    logic signed [sbc_pkg::POS_W-1:0] o_out_vel_x;
    logic signed [sbc_pkg::POS_W-1:0] o_out_vel_y;
    logic signed [sbc_pkg::POS_W-1:0] o_out_vel_z;
    logic [sbc_pkg::MASK_W-1:0]       o_contact_mask;

    logic [sbc_pkg::EXT_W-1:0] cfg_width  = sbc_pkg::EXT_INIT;
    logic [sbc_pkg::EXT_W-1:0] cfg_height = sbc_pkg::EXT_INIT;
    logic [sbc_pkg::EXT_W-1:0] cfg_depth  = sbc_pkg::EXT_INIT;

    t_correction pending_corrections[$];
    int          fail_count     = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          stall_requests = 0;
    int          stall_served   = 0;
    int          stall_left     = 0;

    swept_box_collision_correct u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_body_x       (i_body_x),
        .i_body_y       (i_body_y),
        .i_body_z       (i_body_z),
        .i_vel_x        (i_vel_x),
        .i_vel_y        (i_vel_y),
        .i_vel_z        (i_vel_z),
        .i_obstacle_x   (i_obstacle_x),
        .i_obstacle_y   (i_obstacle_y),
        .i_obstacle_z   (i_obstacle_z),
        .i_obstacle_w   (i_obstacle_w),
        .i_obstacle_h   (i_obstacle_h),
        .i_obstacle_d   (i_obstacle_d),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_out_vel_x    (o_out_vel_x),
        .o_out_vel_y    (o_out_vel_y),
        .o_out_vel_z    (o_out_vel_z),
        .o_contact_mask (o_contact_mask)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic signed [sbc_pkg::POS_W-1:0] clamp_q16(input longint v);
        if (v > Q_MAX) begin
            return 32'sh7fffffff;
        end else if (v < Q_MIN) begin
            return 32'sh80000000;
        end
        return v[sbc_pkg::POS_W-1:0];
    endfunction

    function automatic bit plane_overlap(input longint a, ea, va, oa, oea,
                                         input longint b, eb, vb, ob, oeb);
        return (a + ea + va > oa) && (a + va < oa + oea) &&
               (b + eb + vb > ob) && (b + vb < ob + oeb);
    endfunction

    function automatic t_correction predict_correction(input t_box_pair p);
        longint      x, y, z, vx, vy, vz, ox, oy, oz, ow, oh, od;
        longint      w, h, d, nvx, tol;
        bit          hit_xy, hit_xz, hit_zy;
        t_correction r;
        x   = $signed(p.bx);
        y   = $signed(p.by);
        z   = $signed(p.bz);
        vx  = $signed(p.vx);
        vy  = $signed(p.vy);
        vz  = $signed(p.vz);
        ox  = $signed(p.ox);
        oy  = $signed(p.oy);
        oz  = $signed(p.oz);
        ow  = p.ow;
        oh  = p.oh;
        od  = p.od;
        w   = cfg_width;
        h   = cfg_height;
        d   = cfg_depth;
        tol = sbc_pkg::Y_TOL;
        nvx = -vx;
        r.x    = p.bx;
        r.y    = p.by;
        r.z    = p.bz;
        r.vx   = p.vx;
        r.vy   = p.vy;
        r.vz   = p.vz;
        r.mask = '0;
        hit_xy = plane_overlap(x, w, nvx, ox, ow, y, h, vy, oy, oh);
        hit_xz = plane_overlap(x, w, nvx, ox, ow, z, d, vz, oz, od);
        hit_zy = plane_overlap(z, d, vz, oz, od, y, h, vy, oy, oh);
        if (hit_xy) begin
            if (z >= oz + od && z + vz < oz + od) begin
                r.vz = '0;
                r.z  = clamp_q16(oz + od);
                r.mask[sbc_pkg::MB_Z_BACK] = 1'b1;
            end else if (z + d <= oz && z + d + vz > oz) begin
                r.vz = '0;
                r.z  = clamp_q16(oz - d);
                r.mask[sbc_pkg::MB_Z_FRONT] = 1'b1;
            end
        end
        if (hit_xz) begin
            if (y >= oy + oh && y + vy < oy + oh) begin
                r.vy = '0;
                r.y  = clamp_q16(oy + oh);
                r.mask[sbc_pkg::MB_Y_ABOVE] = 1'b1;
            end else if (y + h - tol <= oy && y + h + vy > oy) begin
                r.vy = '0;
                r.y  = clamp_q16(oy - h);
                r.mask[sbc_pkg::MB_Y_BELOW] = 1'b1;
            end
        end
        if (hit_zy) begin
            if (x + w <= ox && x + w + nvx > ox) begin
                r.vx = '0;
                r.x  = clamp_q16(ox - w);
                r.mask[sbc_pkg::MB_X_RIGHT] = 1'b1;
            end else if (x >= ox + ow && x + nvx < ox + ow) begin
                r.vx = '0;
                r.x  = clamp_q16(ox + ow);
                r.mask[sbc_pkg::MB_X_LEFT] = 1'b1;
            end
        end
        return r;
    endfunction

    // Place the box near one obstacle face per axis, mostly crossing it.
    function automatic t_box_pair near_pair();
        longint    o [3];
        longint    oe [3];
        longint    e [3];
        longint    a [3];
        longint    v [3];
        longint    k, m, r;
        t_box_pair p;
        e[0] = cfg_width;
        e[1] = cfg_height;
        e[2] = cfg_depth;
        for (int i = 0; i < 3; i++) begin
            r = $urandom_range(0, 9);
            if (r < 8) begin
                r    = $urandom_range(0, 2 ** 25);
                o[i] = r - 2 ** 24;
            end else if (r == 8) begin
                r    = $urandom_range(0, 8 * ONE);
                o[i] = Q_MAX - r;
            end else begin
                r    = $urandom_range(0, 8 * ONE);
                o[i] = Q_MIN + r;
            end
            oe[i] = $urandom_range(0, 4 * ONE);
            k = 0;
            if ($urandom_range(0, 3) != 0) begin
                k = $urandom_range(0, 2 * ONE);
            end
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 2);
                m = k + r - 1;
            end else begin
                m = $urandom_range(0, 3 * ONE);
            end
            case ($urandom_range(0, 3))
                0: begin
                    a[i] = o[i] - e[i] - k;
                    v[i] = m;
                end
                1: begin
                    a[i] = o[i] + oe[i] + k;
                    v[i] = -m;
                end
                2: begin
                    r    = $urandom_range(0, 700);
                    a[i] = o[i] - e[i] + r;
                    v[i] = m;
                end
                default: begin
                    r    = $urandom_range(0, 4 * ONE);
                    a[i] = o[i] + r - e[i] / 2;
                    v[i] = $urandom_range(0, 1) ? m : -m;
                end
            endcase
        end
        p.bx = clamp_q16(a[0]);
        p.by = clamp_q16(a[1]);
        p.bz = clamp_q16(a[2]);
        p.vx = clamp_q16(-v[0]);
        p.vy = clamp_q16(v[1]);
        p.vz = clamp_q16(v[2]);
        p.ox = clamp_q16(o[0]);
        p.oy = clamp_q16(o[1]);
        p.oz = clamp_q16(o[2]);
        p.ow = sbc_pkg::EXT_W'(oe[0]);
        p.oh = sbc_pkg::EXT_W'(oe[1]);
        p.od = sbc_pkg::EXT_W'(oe[2]);
        return p;
    endfunction

    function automatic t_box_pair random_pair();
        t_box_pair p;
        if ($urandom_range(0, 99) < 15) begin
            p.bx = $urandom;
            p.by = $urandom;
            p.bz = $urandom;
            p.vx = $urandom;
            p.vy = $urandom;
            p.vz = $urandom;
            p.ox = $urandom;
            p.oy = $urandom;
            p.oz = $urandom;
            p.ow = sbc_pkg::EXT_W'($urandom);
            p.oh = sbc_pkg::EXT_W'($urandom);
            p.od = sbc_pkg::EXT_W'($urandom);
            return p;
        end
        return near_pair();
    endfunction

    task automatic send_box_pair(input t_box_pair p);
        bit gap_started;
        i_valid      <= 1'b1;
        i_body_x     <= p.bx;
        i_body_y     <= p.by;
        i_body_z     <= p.bz;
        i_vel_x      <= p.vx;
        i_vel_y      <= p.vy;
        i_vel_z      <= p.vz;
        i_obstacle_x <= p.ox;
        i_obstacle_y <= p.oy;
        i_obstacle_z <= p.oz;
        i_obstacle_w <= p.ow;
        i_obstacle_h <= p.oh;
        i_obstacle_d <= p.od;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_corrections.push_back(predict_correction(p));
        gap_started = 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            if (!gap_started) i_valid <= 1'b0;
            gap_started = 1'b1;
            @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_corrections.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_body_extents(input logic [sbc_pkg::EXT_W-1:0] w, h, d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= sbc_pkg::CFG_BODY_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= sbc_pkg::CFG_BODY_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_idx  <= sbc_pkg::CFG_BODY_DEPTH;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_width  = w;
        cfg_height = h;
        cfg_depth  = d;
    endtask

    task automatic run_random_phase(input int count, input logic [sbc_pkg::EXT_W-1:0] w, h, d);
        set_body_extents(w, h, d);
        repeat (count) send_box_pair(random_pair());
        drain_results();
    endtask

    task automatic test_directed_faces();
        send_idle_pct = 22;
        recv_idle_pct = 74;
        send_box_pair('{ONE/2, ONE/2, 2*ONE, 0, 0, -ONE/2, 0, 0, 0, 2*ONE, 2*ONE, 2*ONE});
        send_box_pair('{ONE/2, ONE/2, -ONE, 0, 0, ONE/2, 0, 0, 0, 2*ONE, 2*ONE, 2*ONE});
        send_box_pair('{ONE/2, 2*ONE, ONE/2, 0, -ONE/2, 0, 0, 0, 0, 2*ONE, 2*ONE, 2*ONE});
        send_box_pair('{ONE/2, -ONE, ONE/2, 0, ONE/2, 0, 0, 0, 0, 2*ONE, 2*ONE, 2*ONE});
        send_box_pair('{ONE/2, -ONE+655, ONE/2, 0, ONE/2, 0, 0, 0, 0, 2*ONE, 2*ONE, 2*ONE});
        send_box_pair('{ONE/2, -ONE+656, ONE/2, 0, ONE/2, 0, 0, 0, 0, 2*ONE, 2*ONE, 2*ONE});
        send_box_pair('{-ONE, ONE/2, ONE/2, -ONE/2, 0, 0, 0, 0, 0, 2*ONE, 2*ONE, 2*ONE});
        send_box_pair('{2*ONE, ONE/2, ONE/2, ONE/2, 0, 0, 0, 0, 0, 2*ONE, 2*ONE, 2*ONE});
        send_box_pair('{-ONE, ONE/2, ONE/2, ONE/2, 0, 0, 0, 0, 0, 2*ONE, 2*ONE, 2*ONE});
        send_box_pair('{-ONE, -ONE, -ONE, -ONE/2, ONE/2, ONE/2, 0, 0, 0,
                        2*ONE, 2*ONE, 2*ONE});
        send_box_pair('{ONE/2, ONE/2, -ONE, 0, 0, 0, 0, 0, 0, 2*ONE, 2*ONE, 2*ONE});
        send_box_pair('{-ONE/2, -ONE/2, ONE, 0, 0, -2*ONE, 0, 0, 0, 0, 0, 0});
        send_box_pair('{20*ONE, -20*ONE, 5*ONE, ONE, ONE, ONE, 0, 0, 0, ONE, ONE, ONE});
        send_box_pair('0);
        send_box_pair('1);
        send_box_pair('{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 31'h0, 31'h0, 31'h0});
        send_box_pair('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff});
        send_box_pair('{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                        32'h80000000, 31'h0, 31'h0, 31'h0});
        send_box_pair('{32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
                        32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555,
                        32'haaaaaaaa, 31'h55555555, 31'h2aaaaaaa, 31'h55555555});
        drain_results();
    endtask

    // With a short body on a flat obstacle both y faces qualify; above must win.
    task automatic test_face_precedence();
        send_idle_pct = 22;
        recv_idle_pct = 74;
        set_body_extents(sbc_pkg::EXT_INIT, 31'd100, sbc_pkg::EXT_INIT);
        send_box_pair('{ONE/2, 0, ONE/2, 0, -1, 0, 0, 0, 0, 2*ONE, 0, 2*ONE});
        send_box_pair('{ONE/2, -50, ONE/2, 0, 1, 0, 0, 0, 0, 2*ONE, 0, 2*ONE});
        drain_results();
    endtask

    task automatic test_random_slow_sink();
        send_idle_pct = 22;
        recv_idle_pct = 74;
        run_random_phase(300, sbc_pkg::EXT_INIT, sbc_pkg::EXT_INIT, sbc_pkg::EXT_INIT);
        run_random_phase(200, '0, '0, '0);
    endtask

    task automatic test_random_slow_source();
        send_idle_pct = 74;
        recv_idle_pct = 22;
        run_random_phase(250, '1, '1, '1);
        run_random_phase(250, sbc_pkg::EXT_W'($urandom_range(0, 8 * ONE)),
                         sbc_pkg::EXT_W'($urandom_range(0, 8 * ONE)),
                         sbc_pkg::EXT_W'($urandom_range(0, 8 * ONE)));
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_requests++;
        repeat (40) send_box_pair(random_pair());
        drain_results();
    endtask

    task automatic test_random_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(200, '0, '1, sbc_pkg::EXT_W'(ONE / 2));
        run_random_phase(250, sbc_pkg::EXT_W'($urandom_range(0, 8 * ONE)),
                         sbc_pkg::EXT_W'($urandom_range(0, 8 * ONE)),
                         sbc_pkg::EXT_W'($urandom_range(0, 8 * ONE)));
    endtask

    always @(posedge i_clk) begin
        if (stall_requests != stall_served) begin
            stall_served = stall_requests;
            stall_left   = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic compare_field(input string name,
                                 input logic [sbc_pkg::POS_W-1:0] want, got);
        if (want !== got) begin
            fail_count++;
            $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_correction want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_corrections.size() == 0) begin
                fail_count++;
                $display("%0t ns: result with no item outstanding", $time);
            end else begin
                want = pending_corrections.pop_front();
                compare_field("out_x", want.x, o_out_x);
                compare_field("out_y", want.y, o_out_y);
                compare_field("out_z", want.z, o_out_z);
                compare_field("out_vel_x", want.vx, o_out_vel_x);
                compare_field("out_vel_y", want.vy, o_out_vel_y);
                compare_field("out_vel_z", want.vz, o_out_vel_z);
                compare_field("contact_mask", sbc_pkg::POS_W'(want.mask),
                              sbc_pkg::POS_W'(o_contact_mask));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** swept_box_collision_correct: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_faces();
        test_face_precedence();
        test_random_slow_sink();
        test_random_slow_source();
        test_output_backpressure();
        test_random_full_rate();
        if (fail_count == 0) begin
            $display("** swept_box_collision_correct: PASSED **");
        end else begin
            $display("** swept_box_collision_correct: FAILED **");
        end
        $finish;
    end

endmodule
